// ===== rtl/erb_pkg.sv =====
// ----------------------------------------------------------------------------
// erb_pkg
// Shared types and constants of the yaw-pitch-roll rotation basis block.
// ----------------------------------------------------------------------------
package erb_pkg;

	localparam int unsigned ANGLE_W = 16;
	localparam int unsigned TRIG_W  = 16;  // signed Q2.14
	localparam int unsigned OUT_W   = 16;

	localparam logic [14:0] Q14_ONE = 15'd16384;
	localparam logic [15:0] QUARTER = 16'd16384;

	// Q30 polynomial coefficients of sin(pi/2*z)
	localparam logic [31:0] C1 = 32'd1686629713;
	localparam logic [31:0] C3 = 32'd693598668;
	localparam logic [31:0] C5 = 32'd85569306;
	localparam logic [31:0] C7 = 32'd5026995;
	localparam logic [31:0] C9 = 32'd172273;

	// one input beat
	typedef struct packed {
		logic [ANGLE_W-1:0] yaw;
		logic [ANGLE_W-1:0] pitch;
		logic [ANGLE_W-1:0] roll;
	} angles_t;

	// sines and cosines handed from the front to the back
	typedef struct packed {
		logic signed [TRIG_W-1:0] sy;
		logic signed [TRIG_W-1:0] cy;
		logic signed [TRIG_W-1:0] sp;
		logic signed [TRIG_W-1:0] cp;
		logic signed [TRIG_W-1:0] sr;
		logic signed [TRIG_W-1:0] cr;
	} trig_t;

	// one result beat
	typedef struct packed {
		logic signed [OUT_W-1:0] fwd_x;
		logic signed [OUT_W-1:0] fwd_y;
		logic signed [OUT_W-1:0] fwd_z;
		logic signed [OUT_W-1:0] left_x;
		logic signed [OUT_W-1:0] left_y;
		logic signed [OUT_W-1:0] left_z;
		logic signed [OUT_W-1:0] up_x;
		logic signed [OUT_W-1:0] up_y;
		logic signed [OUT_W-1:0] up_z;
	} basis_t;

	// Q30 truncating multiply
	function automatic logic [31:0] mul_q30(input logic [31:0] a, input logic [31:0] b);
		logic [63:0] p;
		p = 64'(a) * 64'(b);
		return 32'(p >> 30);
	endfunction

	// round a Q42 value to Q14 half away from zero and saturate
	function automatic logic signed [OUT_W-1:0] to_q14(input logic signed [47:0] v);
		logic        neg;
		logic [47:0] mag;
		logic [20:0] r;
		neg = v[47];
		mag = neg ? 48'(-v) : 48'(v);
		r   = 21'((mag + (48'd1 << 27)) >> 28);
		if (r > 21'(Q14_ONE))
			r = 21'(Q14_ONE);
		return neg ? -OUT_W'(r) : OUT_W'(r);
	endfunction

endpackage

// ===== rtl/erb_sine.sv =====
// ----------------------------------------------------------------------------
// erb_sine
// Pipelined quarter-wave sine of a binary angle, Q2.14 result. One
// polynomial step per stage; one angle per cycle while en is high.
// ----------------------------------------------------------------------------
module erb_sine (
	input  logic                             clk,
	input  logic                             en,
	input  logic [erb_pkg::ANGLE_W-1:0]      angle,
	output logic signed [erb_pkg::TRIG_W-1:0] sine
);
	import erb_pkg::*;

	localparam int unsigned NST = 6;

	logic [14:0] z_in;
	logic [31:0] z2_s [NST];
	logic [14:0] z_s  [NST];
	logic [31:0] t_s  [NST];
	logic        neg_s [NST];
	logic [31:0] coef [NST];
	logic [31:0] s_lo;
	logic [16:0] r_full;

	// quadrant fold: mirrored fraction for odd quadrants
	always_comb begin
		if (angle[14])
			z_in = 15'(QUARTER) - {1'b0, angle[13:0]};
		else
			z_in = {1'b0, angle[13:0]};
	end

	assign coef[0] = 32'd0;
	assign coef[1] = C7;
	assign coef[2] = C5;
	assign coef[3] = C3;
	assign coef[4] = C1;
	assign coef[5] = 32'd0;

	// stage 0: z squared in Q30
	always_ff @(posedge clk) begin
		if (en) begin
			z_s[0]   <= z_in;
			z2_s[0]  <= 32'(({17'd0, z_in} * {17'd0, z_in}) << 2);
			t_s[0]   <= C9;
			neg_s[0] <= angle[15];
		end
	end

	// Horner steps, one per stage
	for (genvar i = 1; i < NST-1; i++) begin : g_horner
		always_ff @(posedge clk) begin
			if (en) begin
				z_s[i]   <= z_s[i-1];
				z2_s[i]  <= z2_s[i-1];
				neg_s[i] <= neg_s[i-1];
				if (i == 1)
					t_s[i] <= coef[i] - mul_q30(z2_s[i-1], t_s[i-1]);
				else
					t_s[i] <= coef[i] - mul_q30(z2_s[i-1], t_s[i-1]);
			end
		end
	end

	// final z*t, Q30
	always_ff @(posedge clk) begin
		if (en) begin
			z_s[NST-1]   <= z_s[NST-2];
			z2_s[NST-1]  <= z2_s[NST-2];
			neg_s[NST-1] <= neg_s[NST-2];
			t_s[NST-1]   <= 32'((48'(z_s[NST-2]) * 48'(t_s[NST-2])) >> 14);
		end
	end

	// round half up to Q14, limit, apply sign
	assign s_lo   = t_s[NST-1];
	assign r_full = 17'((33'(s_lo) + 33'd32768) >> 16);

	always_ff @(posedge clk) begin
		if (en) begin
			if (r_full > 17'(Q14_ONE))
				sine <= neg_s[NST-1] ? -TRIG_W'(Q14_ONE) : TRIG_W'(Q14_ONE);
			else
				sine <= neg_s[NST-1] ? -TRIG_W'(r_full) : TRIG_W'(r_full);
		end
	end

	logic unused_z2;
	assign unused_z2 = ^z2_s[NST-1];
endmodule

// ===== rtl/erb_front.sv =====
// ----------------------------------------------------------------------------
// erb_front
// Front end: takes angle beats and forms the six sines and cosines in a
// 7-stage pipeline that advances while en is high.
// ----------------------------------------------------------------------------
module erb_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_vld,
	input  erb_pkg::angles_t in_ang,
	output logic             out_vld,
	output erb_pkg::trig_t   out_trig
);
	import erb_pkg::*;

	localparam int unsigned LAT = 7;

	logic [LAT-1:0] vld_q;

	erb_sine u_sy (.clk, .en, .angle(in_ang.yaw),             .sine(out_trig.sy));
	erb_sine u_cy (.clk, .en, .angle(in_ang.yaw + QUARTER),   .sine(out_trig.cy));
	erb_sine u_sp (.clk, .en, .angle(in_ang.pitch),           .sine(out_trig.sp));
	erb_sine u_cp (.clk, .en, .angle(in_ang.pitch + QUARTER), .sine(out_trig.cp));
	erb_sine u_sr (.clk, .en, .angle(in_ang.roll),            .sine(out_trig.sr));
	erb_sine u_cr (.clk, .en, .angle(in_ang.roll + QUARTER),  .sine(out_trig.cr));

	// valid shift line
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (en)
			vld_q <= {vld_q[LAT-2:0], in_vld};
	end

	assign out_vld = vld_q[LAT-1];
endmodule

// ===== rtl/erb_back.sv =====
// ----------------------------------------------------------------------------
// erb_back
// Back end: products of the sines and cosines, sums, rounding and
// saturation. Three stages, advancing while en is high.
// ----------------------------------------------------------------------------
module erb_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_vld,
	input  erb_pkg::trig_t in_trig,
	output logic           out_vld,
	output erb_pkg::basis_t out_basis
);
	import erb_pkg::*;

	typedef logic signed [31:0] p32_t;
	typedef logic signed [47:0] p48_t;

	// stage 1: pairwise products, Q28
	p32_t cycp_s1, sycp_s1, sp_s1, sycr_s1, cysp_s1, cycr_s1, sysp_s1, cpsr_s1;
	p32_t sysr_s1, cysr_s1, cpcr_s1;
	logic signed [15:0] sr_s1, cr_s1;
	// stage 2: Q42 sums
	p48_t v_s2 [9];
	logic [2:0] vld_q;

	always_ff @(posedge clk) begin
		if (en) begin
			cycp_s1 <= in_trig.cy * in_trig.cp;
			sycp_s1 <= in_trig.sy * in_trig.cp;
			sp_s1   <= 32'(in_trig.sp);
			sycr_s1 <= in_trig.sy * in_trig.cr;
			cysp_s1 <= in_trig.cy * in_trig.sp;
			cycr_s1 <= in_trig.cy * in_trig.cr;
			sysp_s1 <= in_trig.sy * in_trig.sp;
			cpsr_s1 <= in_trig.cp * in_trig.sr;
			sysr_s1 <= in_trig.sy * in_trig.sr;
			cysr_s1 <= in_trig.cy * in_trig.sr;
			cpcr_s1 <= in_trig.cp * in_trig.cr;
			sr_s1   <= in_trig.sr;
			cr_s1   <= in_trig.cr;
		end
	end

	// stage 2: second multiply (Q28 x Q14) and an add for the components that need one
	always_ff @(posedge clk) begin
		if (en) begin
			v_s2[0] <= 48'(cycp_s1) <<< 14;
			v_s2[1] <= 48'(sycp_s1) <<< 14;
			v_s2[2] <= -(48'(sp_s1) <<< 28);
			v_s2[3] <= -(48'(sycr_s1) <<< 14) + 48'(cysp_s1) * 48'(sr_s1);
			v_s2[4] <= (48'(cycr_s1) <<< 14) + 48'(sysp_s1) * 48'(sr_s1);
			v_s2[5] <= 48'(cpsr_s1) <<< 14;
			v_s2[6] <= (48'(sysr_s1) <<< 14) + 48'(cysp_s1) * 48'(cr_s1);
			v_s2[7] <= -(48'(cysr_s1) <<< 14) + 48'(sysp_s1) * 48'(cr_s1);
			v_s2[8] <= 48'(cpcr_s1) <<< 14;
		end
	end

	// stage 3: round and saturate
	always_ff @(posedge clk) begin
		if (en) begin
			out_basis.fwd_x  <= to_q14(v_s2[0]);
			out_basis.fwd_y  <= to_q14(v_s2[1]);
			out_basis.fwd_z  <= to_q14(v_s2[2]);
			out_basis.left_x <= to_q14(v_s2[3]);
			out_basis.left_y <= to_q14(v_s2[4]);
			out_basis.left_z <= to_q14(v_s2[5]);
			out_basis.up_x   <= to_q14(v_s2[6]);
			out_basis.up_y   <= to_q14(v_s2[7]);
			out_basis.up_z   <= to_q14(v_s2[8]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else if (en)
			vld_q <= {vld_q[1:0], in_vld};
	end

	assign out_vld = vld_q[2];
endmodule

// ===== rtl/erb_fifo.sv =====
// ----------------------------------------------------------------------------
// erb_fifo
// Small register queue with a count-based empty flag and an occupancy count.
// ----------------------------------------------------------------------------
module erb_fifo #(
	parameter int unsigned WIDTH = 96,
	parameter int unsigned DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty,
	output logic [$clog2(DEPTH+1)-1:0] count
);
	localparam int unsigned AW = $clog2(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_q, rd_q;
	logic [$clog2(DEPTH+1)-1:0] cnt_q;
	logic do_push, do_pop;

	assign do_push = push && (cnt_q != ($clog2(DEPTH+1))'(DEPTH));
	assign do_pop  = pop && (cnt_q != '0);

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_q] <= wdata;
	end

	// pointers wrap at DEPTH
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_q <= (wr_q == AW'(DEPTH-1)) ? '0 : wr_q + 1'b1;
			if (do_pop)
				rd_q <= (rd_q == AW'(DEPTH-1)) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + (do_push ? 1'b1 : 1'b0) - (do_pop ? 1'b1 : 1'b0);
		end
	end

	assign rdata = mem_q[rd_q];
	assign empty = (cnt_q == '0);
	assign count = cnt_q;
endmodule

// ===== rtl/euler_to_rotation_basis.sv =====
// ----------------------------------------------------------------------------
// euler_to_rotation_basis
// Yaw-pitch-roll (Z-Y-X) binary angles to the forward, left and up basis
// vectors in signed Q2.14.
// ----------------------------------------------------------------------------
// One angle beat per cycle is taken while full is low, and one basis beat
// per cycle is given while pop is high and empty is low. A result passes
// through 7 sine polynomial stages in the front, a write into the trig
// queue, 3 product, sum and rounding stages in the back, and a write into
// the result queue. The front never stalls; it is followed by a 9-deep
// trig queue, and the back by a 5-deep result queue.
// Each side holds one credit per beat it can have in flight, so full rises
// only when the front pipeline plus the trig queue hold 9 beats, and the back
// pauses only when its pipeline plus the result queue hold 5. With pop held
// high neither limit is reached and the block runs at one beat per cycle.
module euler_to_rotation_basis (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  logic [erb_pkg::ANGLE_W-1:0]         yaw_angle,
	input  logic [erb_pkg::ANGLE_W-1:0]         pitch_angle,
	input  logic [erb_pkg::ANGLE_W-1:0]         roll_angle,
	output logic                                empty,
	input  logic                                pop,
	output logic signed [erb_pkg::OUT_W-1:0]    fwd_x,
	output logic signed [erb_pkg::OUT_W-1:0]    fwd_y,
	output logic signed [erb_pkg::OUT_W-1:0]    fwd_z,
	output logic signed [erb_pkg::OUT_W-1:0]    left_x,
	output logic signed [erb_pkg::OUT_W-1:0]    left_y,
	output logic signed [erb_pkg::OUT_W-1:0]    left_z,
	output logic signed [erb_pkg::OUT_W-1:0]    up_x,
	output logic signed [erb_pkg::OUT_W-1:0]    up_y,
	output logic signed [erb_pkg::OUT_W-1:0]    up_z
);
	import erb_pkg::*;

	localparam int unsigned FLAT = 7;
	localparam int unsigned BLAT = 3;
	// credits cover the pipeline plus room for beats waiting in its queue
	localparam int unsigned TQD  = FLAT + 2;
	localparam int unsigned RQD  = BLAT + 2;

	angles_t ang;
	trig_t   f_trig, q_trig;
	basis_t  b_out, r_out;
	logic    f_vld, b_vld;
	logic    acc;
	logic    tq_empty, rq_empty, b_adv;
	logic [$clog2(TQD+1)-1:0] tq_cnt;
	logic [$clog2(RQD+1)-1:0] rq_cnt;
	logic [$clog2(FLAT+1)-1:0] f_fly_q;
	logic [$clog2(BLAT+1)-1:0] b_fly_q;
	logic    f_take, b_take;

	assign ang = '{yaw: yaw_angle, pitch: pitch_angle, roll: roll_angle};

	// front runs freely; full guards the trig queue against beats in flight
	assign acc  = push && !full;
	assign full = (32'(f_fly_q) + 32'(tq_cnt)) >= TQD;

	erb_front u_front (
		.clk, .arst_n, .en(1'b1), .in_vld(acc), .in_ang(ang),
		.out_vld(f_vld), .out_trig(f_trig)
	);

	erb_fifo #(.WIDTH($bits(trig_t)), .DEPTH(TQD)) u_tq (
		.clk, .arst_n, .push(f_vld), .wdata(f_trig), .pop(b_take),
		.rdata(q_trig), .empty(tq_empty), .count(tq_cnt)
	);

	// back pulls a beat when the result queue has room for it
	assign b_adv  = (32'(b_fly_q) + 32'(rq_cnt)) < RQD;
	assign b_take = b_adv && !tq_empty;

	erb_back u_back (
		.clk, .arst_n, .en(1'b1), .in_vld(b_take), .in_trig(q_trig),
		.out_vld(b_vld), .out_basis(b_out)
	);

	erb_fifo #(.WIDTH($bits(basis_t)), .DEPTH(RQD)) u_rq (
		.clk, .arst_n, .push(b_vld), .wdata(b_out), .pop(pop),
		.rdata(r_out), .empty(rq_empty), .count(rq_cnt)
	);

	// in-flight beat counters
	assign f_take = f_vld;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			f_fly_q <= '0;
			b_fly_q <= '0;
		end else begin
			f_fly_q <= f_fly_q + (acc ? 1'b1 : 1'b0) - (f_take ? 1'b1 : 1'b0);
			b_fly_q <= b_fly_q + (b_take ? 1'b1 : 1'b0) - (b_vld ? 1'b1 : 1'b0);
		end
	end

	assign empty  = rq_empty;
	assign fwd_x  = r_out.fwd_x;
	assign fwd_y  = r_out.fwd_y;
	assign fwd_z  = r_out.fwd_z;
	assign left_x = r_out.left_x;
	assign left_y = r_out.left_y;
	assign left_z = r_out.left_z;
	assign up_x   = r_out.up_x;
	assign up_y   = r_out.up_y;
	assign up_z   = r_out.up_z;

	// a beat leaving the front always finds room in the trig queue
	a_tq_room: assert property (@(posedge clk) disable iff (!arst_n)
		f_vld |-> (32'(tq_cnt) < TQD || b_take)) else $error("trig queue overrun");

	// a finished basis always finds room in the result queue
	a_rq_room: assert property (@(posedge clk) disable iff (!arst_n)
		b_vld |-> (32'(rq_cnt) < RQD || (pop && !rq_empty))) else $error("result queue overrun");

	// front in-flight count plus the trig queue stays within its budget
	a_fly: assert property (@(posedge clk) disable iff (!arst_n)
		(32'(f_fly_q) + 32'(tq_cnt)) <= TQD) else $error("front over budget");
endmodule
